// File: sv/md4he_pkg.sv
package md4he_pkg;

    localparam int WORD_W    = 32;
    localparam int BUF_WORDS = 16;
    localparam int BUF_AW    = $clog2(BUF_WORDS);
    localparam int PC_W      = 4;
    localparam int RND_W     = 6;

    localparam logic [WORD_W-1:0] CHAIN_IV [4] = '{
        32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476
    };
    localparam logic [WORD_W-1:0] K2 = 32'h5a82_7999;
    localparam logic [WORD_W-1:0] K3 = 32'h6ed9_eba1;
    localparam logic [7:0]        PAD_MARK = 8'h80;

    localparam logic [BUF_AW-1:0] LEN_ADDR_LO = BUF_AW'(56 / 4);
    localparam logic [BUF_AW-1:0] LEN_ADDR_HI = BUF_AW'(56 / 4 + 1);
    localparam logic [BUF_AW:0]   ZERO_LIMIT_LEN  = (BUF_AW + 1)'(56 / 4);
    localparam logic [BUF_AW:0]   ZERO_LIMIT_FULL = (BUF_AW + 1)'(BUF_WORDS);
    localparam logic [RND_W-1:0]  ROUND_LAST = RND_W'(47);

    localparam logic [4:0] ROT1 [4] = '{5'd3, 5'd7, 5'd11, 5'd19};
    localparam logic [4:0] ROT2 [4] = '{5'd3, 5'd5, 5'd9,  5'd13};
    localparam logic [4:0] ROT3 [4] = '{5'd3, 5'd9, 5'd11, 5'd15};

    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_LOAD,
        OP_ROUND,
        OP_ADD,
        OP_PAD,
        OP_ZERO,
        OP_SPILL,
        OP_LEN_LO,
        OP_LEN_HI,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_DISPATCH,
        C_RND_MORE,
        C_FINAL,
        C_IN_PAD,
        C_NOT_LAST,
        C_ZERO_MORE,
        C_SPILL,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic blk_full;
        logic rnd_more;
        logic final_blk;
        logic in_pad;
        logic last;
        logic zero_more;
        logic spill;
        logic out_busy;
    } t_status;

    localparam logic [PC_W-1:0] P_IDLE  = PC_W'(0);
    localparam logic [PC_W-1:0] P_CMP   = PC_W'(1);
    localparam logic [PC_W-1:0] P_ROUND = PC_W'(2);
    localparam logic [PC_W-1:0] P_ADD   = PC_W'(3);
    localparam logic [PC_W-1:0] P_RET_F = PC_W'(4);
    localparam logic [PC_W-1:0] P_RET_P = PC_W'(5);
    localparam logic [PC_W-1:0] P_RET_L = PC_W'(6);
    localparam logic [PC_W-1:0] P_PAD   = PC_W'(7);
    localparam logic [PC_W-1:0] P_ZFILL = PC_W'(8);
    localparam logic [PC_W-1:0] P_SPILL = PC_W'(9);
    localparam logic [PC_W-1:0] P_LENLO = PC_W'(10);
    localparam logic [PC_W-1:0] P_LENHI = PC_W'(11);
    localparam logic [PC_W-1:0] P_EMIT  = PC_W'(12);
    localparam logic [PC_W-1:0] P_DONE  = PC_W'(13);

    function automatic t_uword uw(t_op op, t_cond cond, logic [PC_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic t_uword ucode(logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            P_IDLE:  w = uw(OP_IDLE,   C_DISPATCH,  P_CMP);
            P_CMP:   w = uw(OP_LOAD,   C_NEXT,      P_IDLE);
            P_ROUND: w = uw(OP_ROUND,  C_RND_MORE,  P_ROUND);
            P_ADD:   w = uw(OP_ADD,    C_NEXT,      P_IDLE);
            P_RET_F: w = uw(OP_NOP,    C_FINAL,     P_EMIT);
            P_RET_P: w = uw(OP_NOP,    C_IN_PAD,    P_ZFILL);
            P_RET_L: w = uw(OP_NOP,    C_NOT_LAST,  P_IDLE);
            P_PAD:   w = uw(OP_PAD,    C_NEXT,      P_IDLE);
            P_ZFILL: w = uw(OP_ZERO,   C_ZERO_MORE, P_ZFILL);
            P_SPILL: w = uw(OP_SPILL,  C_SPILL,     P_CMP);
            P_LENLO: w = uw(OP_LEN_LO, C_NEXT,      P_IDLE);
            P_LENHI: w = uw(OP_LEN_HI, C_ALWAYS,    P_CMP);
            P_EMIT:  w = uw(OP_EMIT,   C_OUT_BUSY,  P_EMIT);
            P_DONE:  w = uw(OP_NOP,    C_ALWAYS,    P_IDLE);
            default: w = uw(OP_NOP,    C_ALWAYS,    P_IDLE);
        endcase
        return w;
    endfunction

    function automatic logic [BUF_AW-1:0] msg_index(logic [RND_W-1:0] rnd);
        logic [BUF_AW-1:0] k;
        logic [BUF_AW-1:0] idx;
        k = rnd[3:0];
        case (rnd[5:4])
            2'd0:    idx = k;
            2'd1:    idx = {k[1:0], k[3:2]};
            default: idx = {k[0], k[1], k[2], k[3]};
        endcase
        return idx;
    endfunction

    function automatic logic [4:0] rot_amount(logic [RND_W-1:0] rnd);
        logic [4:0] s;
        case (rnd[5:4])
            2'd0:    s = ROT1[rnd[1:0]];
            2'd1:    s = ROT2[rnd[1:0]];
            default: s = ROT3[rnd[1:0]];
        endcase
        return s;
    endfunction

    function automatic logic [WORD_W-1:0] round_f(logic [RND_W-1:0] rnd,
                                                  logic [WORD_W-1:0] b,
                                                  logic [WORD_W-1:0] c,
                                                  logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] f;
        case (rnd[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(logic [RND_W-1:0] rnd);
        logic [WORD_W-1:0] k;
        case (rnd[5:4])
            2'd0:    k = '0;
            2'd1:    k = K2;
            default: k = K3;
        endcase
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] rol(logic [WORD_W-1:0] x, logic [4:0] s);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} << s;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

endpackage

// File: sv/md4he_ram.sv
module md4he_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/md4he_seq.sv
module md4he_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_has_byte,
    input  logic               i_last,
    input  md4he_pkg::t_status i_status,
    output md4he_pkg::t_uword  o_ctl
);

    logic [md4he_pkg::PC_W-1:0] r_pc;
    logic [md4he_pkg::PC_W-1:0] n_pc;
    md4he_pkg::t_uword          ctl;
    logic                       take;

    assign ctl   = md4he_pkg::ucode(r_pc);
    assign o_ctl = ctl;

    always_comb begin
        case (ctl.cond)
            md4he_pkg::C_ALWAYS:    take = 1'b1;
            md4he_pkg::C_RND_MORE:  take = i_status.rnd_more;
            md4he_pkg::C_FINAL:     take = i_status.final_blk;
            md4he_pkg::C_IN_PAD:    take = i_status.in_pad;
            md4he_pkg::C_NOT_LAST:  take = !i_status.last;
            md4he_pkg::C_ZERO_MORE: take = i_status.zero_more;
            md4he_pkg::C_SPILL:     take = i_status.spill;
            md4he_pkg::C_OUT_BUSY:  take = i_status.out_busy;
            default:                take = 1'b0;
        endcase
    end

    always_comb begin
        if (ctl.cond == md4he_pkg::C_DISPATCH) begin
            if (i_accept && i_has_byte && i_status.blk_full) begin
                n_pc = ctl.target;
            end else if (i_accept && i_last) begin
                n_pc = md4he_pkg::P_PAD;
            end else begin
                n_pc = r_pc;
            end
        end else if (take) begin
            n_pc = ctl.target;
        end else begin
            n_pc = r_pc + md4he_pkg::PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= md4he_pkg::P_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: sv/md4he_dp.sv
module md4he_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  md4he_pkg::t_uword  i_ctl,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_has_byte,
    input  logic               i_last,
    input  logic               i_out_stall,
    output md4he_pkg::t_status o_status,
    output logic               o_valid,
    output logic [63:0]        o_digest_low,
    output logic [63:0]        o_digest_high
);

    localparam int W  = md4he_pkg::WORD_W;
    localparam int AW = md4he_pkg::BUF_AW;
    localparam int RW = md4he_pkg::RND_W;

    logic [W-1:0]    r_chain [4];
    logic [W-1:0]    r_a, r_b, r_c, r_d;
    logic [W-1:0]    r_acc, n_acc;
    logic [5:0]      r_fill;
    logic [63:0]     r_count;
    logic [RW-1:0]   r_rnd;
    logic [AW:0]     r_wp;
    logic            r_last, r_in_pad, r_spill, r_final;
    logic            r_out_valid;
    logic [63:0]     r_dig_lo, r_dig_hi;

    logic            byte_in;
    logic            out_busy;
    logic            zero_more;
    logic [AW:0]     zero_limit;
    logic [W-1:0]    pad_word;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [W-1:0]    wdata;
    logic [AW-1:0]   raddr;
    logic [W-1:0]    rdata;
    logic [W-1:0]    step_sum;
    logic [W-1:0]    step_out;
    logic            emit_go;

    assign byte_in    = i_accept && i_has_byte;
    assign out_busy   = r_out_valid && i_out_stall;
    assign zero_limit = r_spill ? md4he_pkg::ZERO_LIMIT_FULL : md4he_pkg::ZERO_LIMIT_LEN;
    assign zero_more  = r_wp < zero_limit;
    assign emit_go    = (i_ctl.op == md4he_pkg::OP_EMIT) && !out_busy;

    assign o_status.blk_full  = &r_fill;
    assign o_status.rnd_more  = r_rnd != md4he_pkg::ROUND_LAST;
    assign o_status.final_blk = r_final;
    assign o_status.in_pad    = r_in_pad;
    assign o_status.last      = r_last;
    assign o_status.zero_more = zero_more;
    assign o_status.spill     = r_spill;
    assign o_status.out_busy  = out_busy;

    always_comb begin
        n_acc = r_acc;
        n_acc[8*r_fill[1:0] +: 8] = i_data_byte;
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (2'(j) < r_fill[1:0]) begin
                pad_word[8*j +: 8] = r_acc[8*j +: 8];
            end else if (2'(j) == r_fill[1:0]) begin
                pad_word[8*j +: 8] = md4he_pkg::PAD_MARK;
            end else begin
                pad_word[8*j +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_fill[5:2];
        wdata = n_acc;
        case (i_ctl.op)
            md4he_pkg::OP_IDLE: begin
                we = byte_in && (&r_fill[1:0]);
            end
            md4he_pkg::OP_PAD: begin
                we    = 1'b1;
                wdata = pad_word;
            end
            md4he_pkg::OP_ZERO: begin
                we    = zero_more;
                waddr = r_wp[AW-1:0];
                wdata = '0;
            end
            md4he_pkg::OP_LEN_LO: begin
                we    = 1'b1;
                waddr = md4he_pkg::LEN_ADDR_LO;
                wdata = r_count[31:0];
            end
            md4he_pkg::OP_LEN_HI: begin
                we    = 1'b1;
                waddr = md4he_pkg::LEN_ADDR_HI;
                wdata = r_count[63:32];
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    assign raddr = (i_ctl.op == md4he_pkg::OP_LOAD) ? md4he_pkg::msg_index('0)
                 : md4he_pkg::msg_index(r_rnd + RW'(1));

    md4he_ram #(
        .WIDTH (md4he_pkg::WORD_W),
        .DEPTH (md4he_pkg::BUF_WORDS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign step_sum = r_a + md4he_pkg::round_f(r_rnd, r_b, r_c, r_d)
                    + rdata + md4he_pkg::round_k(r_rnd);
    assign step_out = md4he_pkg::rol(step_sum, md4he_pkg::rot_amount(r_rnd));

    always_ff @(posedge i_clk) begin
        if (byte_in) begin
            r_acc <= n_acc;
        end
        case (i_ctl.op)
            md4he_pkg::OP_LOAD: begin
                r_a <= r_chain[0];
                r_b <= r_chain[1];
                r_c <= r_chain[2];
                r_d <= r_chain[3];
            end
            md4he_pkg::OP_ROUND: begin
                r_a <= r_d;
                r_b <= step_out;
                r_c <= r_b;
                r_d <= r_c;
            end
            default: begin
                r_a <= r_a;
            end
        endcase
        if (emit_go) begin
            r_dig_lo <= {r_chain[1], r_chain[0]};
            r_dig_hi <= {r_chain[3], r_chain[2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_chain[i] <= md4he_pkg::CHAIN_IV[i];
            end
        end else if (i_ctl.op == md4he_pkg::OP_ADD) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
        end else if (emit_go) begin
            for (int i = 0; i < 4; i++) begin
                r_chain[i] <= md4he_pkg::CHAIN_IV[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_count     <= '0;
            r_rnd       <= '0;
            r_wp        <= '0;
            r_last      <= 1'b0;
            r_in_pad    <= 1'b0;
            r_spill     <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_last <= i_last;
            end
            if (byte_in) begin
                r_fill  <= r_fill + 6'd1;
                r_count <= r_count + 64'd8;
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctl.op)
                md4he_pkg::OP_LOAD: begin
                    r_rnd <= '0;
                end
                md4he_pkg::OP_ROUND: begin
                    r_rnd <= r_rnd + RW'(1);
                end
                md4he_pkg::OP_PAD: begin
                    r_wp     <= {1'b0, r_fill[5:2]} + (AW + 1)'(1);
                    r_spill  <= r_fill[5:2] >= md4he_pkg::LEN_ADDR_LO;
                    r_in_pad <= 1'b1;
                end
                md4he_pkg::OP_ZERO: begin
                    if (zero_more) begin
                        r_wp <= r_wp + (AW + 1)'(1);
                    end
                end
                md4he_pkg::OP_SPILL: begin
                    if (r_spill) begin
                        r_spill <= 1'b0;
                        r_wp    <= '0;
                    end
                end
                md4he_pkg::OP_LEN_HI: begin
                    r_final <= 1'b1;
                end
                md4he_pkg::OP_EMIT: begin
                    if (!out_busy) begin
                        r_fill   <= '0;
                        r_count  <= '0;
                        r_last   <= 1'b0;
                        r_in_pad <= 1'b0;
                        r_final  <= 1'b0;
                    end
                end
                default: begin
                    r_rnd <= r_rnd;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_digest_low  = r_dig_lo;
    assign o_digest_high = r_dig_hi;

endmodule

// File: sv/md4_hash_engine_core.sv
// MD4 digest engine, one message byte per item. While idle the block takes one
// item per cycle. A byte that completes a 64-byte block holds the input off
// while the 48 MD4 steps run one per cycle through a single round unit
// reading the 16-word block buffer, framed by load, add-back and return steps
// of the control program. An item marked last holds the input off while the
// padding, zeros and bit length are written and compressed, spilling into a
// second block when needed, after the block's own compression when its byte
// also completes a block; the digest then appears in an output register,
// which may still be waiting to be taken while the next message is streamed
// in, and the next last item holds until that earlier digest has been taken.
module md4_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_low,
    output logic [63:0] o_digest_high
);

    md4he_pkg::t_uword  ctl;
    md4he_pkg::t_status status;
    logic               accept;

    assign o_stall = ctl.op != md4he_pkg::OP_IDLE;
    assign accept  = i_valid && !o_stall;

    md4he_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_has_byte (i_has_byte),
        .i_last     (i_last),
        .i_status   (status),
        .o_ctl      (ctl)
    );

    md4he_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_last        (i_last),
        .i_out_stall   (i_stall),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_digest_low  (o_digest_low),
        .o_digest_high (o_digest_high)
    );

endmodule

// File: sv/md4he_chk.sv
module md4he_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_has_byte,
    input logic        i_last,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_digest_low,
    input logic [63:0] o_digest_high
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_valid && i_stall |=> o_valid)
        else $error("digest dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_valid && i_stall |=> $stable(o_digest_low) && $stable(o_digest_high))
        else $error("digest changed while stalled");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_valid && !o_stall && i_last |=> o_stall)
        else $error("no padding pass after last item");

    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_valid && !o_stall && !i_has_byte && !i_last |=> !o_stall)
        else $error("empty item started work");

endmodule

bind md4_hash_engine_core md4he_chk u_md4he_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_has_byte    (i_has_byte),
    .i_last        (i_last),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_digest_low  (o_digest_low),
    .o_digest_high (o_digest_high)
);

// File: dv/md4_hash_engine_core_check.sv
`timescale 1ns / 100ps

module md4_hash_engine_core_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_digest_low,
    input  logic [63:0] i_digest_high,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    localparam int LEN_OFFSET  = 56;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } digest_t;

    logic [31:0] chain [4];
    logic [7:0]  blk [64];
    logic [5:0]  fill;
    logic [63:0] nbits;
    digest_t     digests_due [$];
    int          errors;
    int          checked;

    function automatic logic [31:0] rotl(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void note_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
        end
    endfunction

    task automatic start_message();
        for (int j = 0; j < 4; j++)
            chain[j] = md4he_pkg::CHAIN_IV[j];
        fill  = '0;
        nbits = '0;
    endtask

    task automatic md4_compress();
        logic [31:0] w [16];
        logic [31:0] r [4];
        logic [31:0] f, t, b, c, d;
        logic [3:0]  k;
        int          ia, s;
        for (int j = 0; j < 16; j++)
            w[j] = {blk[4*j+3], blk[4*j+2], blk[4*j+1], blk[4*j]};
        for (int j = 0; j < 4; j++)
            r[j] = chain[j];
        for (int j = 0; j < 48; j++) begin
            ia = (4 - (j % 4)) % 4;
            k  = 4'(j % 16);
            b  = r[(ia + 1) % 4];
            c  = r[(ia + 2) % 4];
            d  = r[(ia + 3) % 4];
            if (j < 16) begin
                f = (b & c) | (~b & d);
                t = w[k];
            end else if (j < 32) begin
                f = (b & c) | (b & d) | (c & d);
                t = w[{k[1:0], k[3:2]}] + md4he_pkg::K2;
            end else begin
                f = b ^ c ^ d;
                t = w[{k[0], k[1], k[2], k[3]}] + md4he_pkg::K3;
            end
            case (j % 4)
                0: s = 3;
                1: s = (j < 16) ? 7 : (j < 32) ? 5 : 9;
                2: s = (j < 16) ? 11 : (j < 32) ? 9 : 11;
                default: s = (j < 16) ? 19 : (j < 32) ? 13 : 15;
            endcase
            r[ia] = rotl(r[ia] + f + t, s);
        end
        for (int j = 0; j < 4; j++)
            chain[j] = chain[j] + r[j];
    endtask

    task automatic absorb_item(logic [7:0] data, logic has, logic fin);
        int      pos;
        digest_t want;
        if (has) begin
            blk[fill] = data;
            nbits     = nbits + 64'd8;
            fill      = fill + 6'd1;
            if (fill == 6'd0) md4_compress();
        end
        if (fin) begin
            pos      = int'(fill);
            blk[pos] = md4he_pkg::PAD_MARK;
            pos++;
            // spill into a second block when the length no longer fits
            if (pos > LEN_OFFSET) begin
                for (int j = pos; j < 64; j++)
                    blk[j] = 8'h00;
                md4_compress();
                pos = 0;
            end
            for (int j = pos; j < LEN_OFFSET; j++)
                blk[j] = 8'h00;
            for (int j = 0; j < 8; j++)
                blk[LEN_OFFSET + j] = nbits[8*j +: 8];
            md4_compress();
            want.lo = {chain[1], chain[0]};
            want.hi = {chain[3], chain[2]};
            digests_due.push_back(want);
            start_message();
        end
    endtask

    always @(posedge i_clk) begin
        digest_t want;
        if (!i_rst_n) begin
            start_message();
            for (int j = 0; j < 64; j++)
                blk[j] = 8'h00;
            digests_due.delete();
            errors  = 0;
            checked = 0;
        end else begin
            // retire the output first: a new last item cannot produce this result
            if (i_out_valid && !i_out_stall) begin
                if (digests_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: digest with none expected: %h %h", $time,
                                 i_digest_high, i_digest_low);
                    end
                end else begin
                    want = digests_due.pop_front();
                    checked++;
                    if (i_digest_low !== want.lo) note_mismatch("digest_low", want.lo, i_digest_low);
                    if (i_digest_high !== want.hi) begin
                        note_mismatch("digest_high", want.hi, i_digest_high);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) absorb_item(i_data_byte, i_has_byte, i_last);
        end
        o_errors  <= errors;
        o_pending <= digests_due.size();
        o_checked <= checked;
    end

endmodule

// File: dv/md4_hash_engine_core_test.sv
`timescale 1ns / 100ps

module md4_hash_engine_core_test;

    localparam int ITEM_TARGET = 1300;
    localparam int LONG_HOLD   = 600;
    localparam int DRAIN       = 200;
    localparam int IDLE_LIMIT  = 4000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_has_byte  = 1'b0;
    logic        i_last      = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_digest_low;
    logic [63:0] o_digest_high;

    int errors, pending, checked;
    int hold_asks = 0;
    int burst_left = 0;
    int n_items = 0;
    int n_offers = 0;
    int n_bytes = 0;
    int n_msgs = 0;

    md4_hash_engine_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_low  (o_digest_low),
        .o_digest_high (o_digest_high)
    );

    md4_hash_engine_core_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_last        (i_last),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_digest_low  (o_digest_low),
        .i_digest_high (o_digest_high),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_item(input logic [7:0] d, input logic h, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_has_byte  <= h;
        i_last      <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_offers++;
        if (h || l) n_items++;
        if (h) n_bytes++;
        if (l) n_msgs++;
    endtask

    task automatic send_message(input int len, input bit last_with_byte, input int noise_pct);
        logic [7:0] b;
        for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            b = 8'($urandom_range(0, 255));
            send_item(b, 1'b1, last_with_byte && (j == len - 1));
        end
        if (!(last_with_byte && len > 0)) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic wait_for_digests();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : receiver
        int mode;
        int mode_left;
        int held;
        mode      = 0;
        mode_left = 0;
        held      = 0;
        forever begin
            @(posedge i_clk);
            // hold off long enough for the block to back up into its input
            if (hold_asks > held) begin
                held++;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int len;
        int msg;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, single byte finishing itself, ignored item mid-message
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'ha5, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'h3c, 1'b1, 1'b1);
        wait_for_digests();

        msg = 0;
        while (n_items < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(0, 20);
                6, 7, 8: len = 64 * $urandom_range(0, 1) + 55 + $urandom_range(0, 10);
                default: len = $urandom_range(0, 200);
            endcase
            send_message(len, 1'($urandom_range(0, 1)), 3);
            msg++;
            if (msg % 25 == 5) hold_asks <= hold_asks + 1;
            if (msg % 20 == 12) wait_for_digests();
        end

        wait_for_digests();
        repeat (DRAIN) @(posedge i_clk);
        $display("Run covered %0d messages, %0d bytes, %0d item offers incl. ignored ones;",
                 n_msgs, n_bytes, n_offers);
        $display("%0d digests compared, %0d errors", checked, errors);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
